/* hdl/tlpq_pkg.sv */
package tlpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_QUEUES      = 3;
    localparam int JOB_W           = 16;
    localparam int ENTRY_W         = 2 * JOB_W;

    localparam logic       OP_ADD      = 1'b0;
    localparam logic       OP_DISPATCH = 1'b1;

    localparam logic [2:0] LEVEL_HIGH   = 3'd1;
    localparam logic [2:0] LEVEL_MEDIUM = 3'd2;
    localparam logic [2:0] LEVEL_LOW    = 3'd3;

    localparam logic [1:0] SERVED_NONE   = 2'd0;
    localparam logic [1:0] SERVED_HIGH   = 2'd1;
    localparam logic [1:0] SERVED_MEDIUM = 2'd2;
    localparam logic [1:0] SERVED_LOW    = 2'd3;

    typedef enum logic [2:0] {
        STS_QUEUED     = 3'd0,
        STS_BAD_LEVEL  = 3'd1,
        STS_FULL       = 3'd2,
        STS_DISPATCHED = 3'd3,
        STS_EMPTY      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } t_state;

    typedef struct packed {
        logic exec;
        logic capture;
    } t_cmd;

    typedef struct packed {
        logic need_read;
    } t_dp_status;

endpackage

/* hdl/tlpq_ctrl.sv */
module tlpq_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    output logic                   o_valid,
    input  logic                   i_stall,
    input  tlpq_pkg::t_dp_status   i_dp_status,
    output tlpq_pkg::t_cmd         o_cmd
);

    tlpq_pkg::t_state r_state;
    tlpq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlpq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = i_dp_status.need_read ? tlpq_pkg::S_READ : tlpq_pkg::S_OUT;
                end
            end
            tlpq_pkg::S_READ: begin
                n_state = tlpq_pkg::S_OUT;
            end
            tlpq_pkg::S_OUT: begin
                if (!i_stall) begin
                    n_state = tlpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tlpq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.exec    = (r_state == tlpq_pkg::S_IDLE) && i_valid;
        o_cmd.capture = (r_state == tlpq_pkg::S_READ);
        o_stall       = (r_state != tlpq_pkg::S_IDLE);
        o_valid       = (r_state == tlpq_pkg::S_OUT);
    end

endmodule

/* hdl/tlpq_datapath.sv */
module tlpq_datapath #(
    parameter int QUEUE_DEPTH = tlpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tlpq_pkg::t_cmd                i_cmd,
    output tlpq_pkg::t_dp_status          o_dp_status,
    input  logic                          i_op,
    input  logic [tlpq_pkg::JOB_W-1:0]    i_job_id,
    input  logic [tlpq_pkg::JOB_W-1:0]    i_burst_length,
    input  logic [2:0]                    i_level,
    output logic [2:0]                    o_status,
    output logic [tlpq_pkg::JOB_W-1:0]    o_out_job_id,
    output logic [tlpq_pkg::JOB_W-1:0]    o_out_burst_length,
    output logic [1:0]                    o_out_level
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int NQ = tlpq_pkg::NUM_QUEUES;

    logic [PW-1:0]               r_rd_ptr  [NQ];
    logic [PW-1:0]               r_wr_ptr  [NQ];
    logic [OW-1:0]               r_occ     [NQ];
    logic [tlpq_pkg::ENTRY_W-1:0] r_rd_data [NQ];

    tlpq_pkg::t_status           r_status;
    logic [tlpq_pkg::JOB_W-1:0]  r_job_id;
    logic [tlpq_pkg::JOB_W-1:0]  r_burst;
    logic [1:0]                  r_level;

    logic [NQ-1:0] w_nonempty;
    logic [NQ-1:0] w_full;
    logic [NQ-1:0] w_add_sel;
    logic [NQ-1:0] w_disp_sel;
    logic [NQ-1:0] w_do_add;
    logic [NQ-1:0] w_do_pop;
    logic          w_level_ok;
    logic [1:0]    w_served;

    always_comb begin
        for (int q = 0; q < NQ; q++) begin
            w_nonempty[q] = (r_occ[q] != '0);
            w_full[q]     = (r_occ[q] == OW'(QUEUE_DEPTH));
        end
        w_add_sel[0]  = (i_level == tlpq_pkg::LEVEL_HIGH);
        w_add_sel[1]  = (i_level == tlpq_pkg::LEVEL_MEDIUM);
        w_add_sel[2]  = (i_level == tlpq_pkg::LEVEL_LOW);
        w_disp_sel[0] = w_nonempty[0];
        w_disp_sel[1] = !w_nonempty[0] && w_nonempty[1];
        w_disp_sel[2] = !w_nonempty[0] && !w_nonempty[1] && w_nonempty[2];
        w_level_ok    = |w_add_sel;
        for (int q = 0; q < NQ; q++) begin
            w_do_add[q] = i_cmd.exec && (i_op == tlpq_pkg::OP_ADD) && w_add_sel[q]
                          && !w_full[q];
            w_do_pop[q] = i_cmd.exec && (i_op == tlpq_pkg::OP_DISPATCH) && w_disp_sel[q];
        end
        priority if (w_disp_sel[0]) begin
            w_served = tlpq_pkg::SERVED_HIGH;
        end else if (w_disp_sel[1]) begin
            w_served = tlpq_pkg::SERVED_MEDIUM;
        end else if (w_disp_sel[2]) begin
            w_served = tlpq_pkg::SERVED_LOW;
        end else begin
            w_served = tlpq_pkg::SERVED_NONE;
        end
        o_dp_status.need_read = (i_op == tlpq_pkg::OP_DISPATCH) && (|w_nonempty);
    end

    for (genvar g = 0; g < NQ; g++) begin : g_queue
        logic [tlpq_pkg::ENTRY_W-1:0] r_mem [QUEUE_DEPTH];

        always_ff @(posedge i_clk) begin
            if (w_do_add[g]) begin
                r_mem[r_wr_ptr[g]] <= {i_job_id, i_burst_length};
            end
            if (w_do_pop[g]) begin
                r_rd_data[g] <= r_mem[r_rd_ptr[g]];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rd_ptr[g] <= '0;
                r_wr_ptr[g] <= '0;
                r_occ[g]    <= '0;
            end else begin
                if (w_do_add[g]) begin
                    r_wr_ptr[g] <= (r_wr_ptr[g] == PW'(QUEUE_DEPTH - 1)) ? '0
                                   : r_wr_ptr[g] + PW'(1);
                    r_occ[g]    <= r_occ[g] + OW'(1);
                end
                if (w_do_pop[g]) begin
                    r_rd_ptr[g] <= (r_rd_ptr[g] == PW'(QUEUE_DEPTH - 1)) ? '0
                                   : r_rd_ptr[g] + PW'(1);
                    r_occ[g]    <= r_occ[g] - OW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_job_id <= '0;
            r_burst  <= '0;
            r_level  <= tlpq_pkg::SERVED_NONE;
            if (i_op == tlpq_pkg::OP_ADD) begin
                priority if (!w_level_ok) begin
                    r_status <= tlpq_pkg::STS_BAD_LEVEL;
                end else if (|(w_add_sel & w_full)) begin
                    r_status <= tlpq_pkg::STS_FULL;
                end else begin
                    r_status <= tlpq_pkg::STS_QUEUED;
                end
            end else if (|w_nonempty) begin
                r_status <= tlpq_pkg::STS_DISPATCHED;
                r_level  <= w_served;
            end else begin
                r_status <= tlpq_pkg::STS_EMPTY;
            end
        end else if (i_cmd.capture) begin
            unique case (r_level)
                tlpq_pkg::SERVED_HIGH: begin
                    {r_job_id, r_burst} <= r_rd_data[0];
                end
                tlpq_pkg::SERVED_MEDIUM: begin
                    {r_job_id, r_burst} <= r_rd_data[1];
                end
                default: begin
                    {r_job_id, r_burst} <= r_rd_data[2];
                end
            endcase
        end
    end

    assign o_status           = r_status;
    assign o_out_job_id       = r_job_id;
    assign o_out_burst_length = r_burst;
    assign o_out_level        = r_level;

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ[0] <= OW'(QUEUE_DEPTH)) && (r_occ[1] <= OW'(QUEUE_DEPTH))
        && (r_occ[2] <= OW'(QUEUE_DEPTH)))
        else $error("queue occupancy beyond depth");

    a_add_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && (i_op == tlpq_pkg::OP_ADD) && (i_level == tlpq_pkg::LEVEL_HIGH)
        && !w_full[0] |=> (r_occ[0] == $past(r_occ[0]) + OW'(1))
        && (r_status == tlpq_pkg::STS_QUEUED))
        else $error("high queue add not filed");

    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !i_cmd.exec |=> $stable(r_occ[0]) && $stable(r_occ[1])
        && $stable(r_occ[2]))
        else $error("occupancy changed without a transaction");

    a_dispatch_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && (i_op == tlpq_pkg::OP_DISPATCH) && (|w_nonempty)
        |=> (r_status == tlpq_pkg::STS_DISPATCHED) && (r_level != tlpq_pkg::SERVED_NONE)
        && $onehot($past(w_do_pop)))
        else $error("dispatch did not pop exactly one queue");
`endif

endmodule

/* hdl/three_level_priority_queue_scheduler.sv */
// An add, or a dispatch that finds every queue empty, loads its result straight into
// the output registers; a dispatch that finds a job goes through the registered read
// of the queue store, then the output load. An output stall holds the result, and the
// controller holds one item at a time, taking no new item until the last is through.
// Reset (synchronous, active low) clears the FSM, pointers and occupancy counts;
// the queue stores are not cleared and are only read after being written.
module three_level_priority_queue_scheduler #(
    parameter int QUEUE_DEPTH = tlpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic [tlpq_pkg::JOB_W-1:0]  i_job_id,
    input  logic [tlpq_pkg::JOB_W-1:0]  i_burst_length,
    input  logic [2:0]                  i_level,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_status,
    output logic [tlpq_pkg::JOB_W-1:0]  o_out_job_id,
    output logic [tlpq_pkg::JOB_W-1:0]  o_out_burst_length,
    output logic [1:0]                  o_out_level
);

    tlpq_pkg::t_cmd       w_cmd;
    tlpq_pkg::t_dp_status w_dp_status;

    tlpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_dp_status (w_dp_status),
        .o_cmd       (w_cmd)
    );

    tlpq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_dp_status        (w_dp_status),
        .i_op               (i_op),
        .i_job_id           (i_job_id),
        .i_burst_length     (i_burst_length),
        .i_level            (i_level),
        .o_status           (o_status),
        .o_out_job_id       (o_out_job_id),
        .o_out_burst_length (o_out_burst_length),
        .o_out_level        (o_out_level)
    );

endmodule

/* dv/job_dispatch_checker.sv */
module job_dispatch_checker #(
    parameter int QUEUE_DEPTH = tlpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_op,
    input  logic [tlpq_pkg::JOB_W-1:0]  i_job_id,
    input  logic [tlpq_pkg::JOB_W-1:0]  i_burst_length,
    input  logic [2:0]                  i_level,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [2:0]                  i_status,
    input  logic [tlpq_pkg::JOB_W-1:0]  i_out_job_id,
    input  logic [tlpq_pkg::JOB_W-1:0]  i_out_burst_length,
    input  logic [1:0]                  i_out_level,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        tlpq_pkg::t_status                status;
        logic [tlpq_pkg::JOB_W-1:0]       job_id;
        logic [tlpq_pkg::JOB_W-1:0]       burst_length;
        logic [1:0]                       level;
    } t_job_result;

    localparam logic [1:0] SERVED_CODE [tlpq_pkg::NUM_QUEUES] =
        '{tlpq_pkg::SERVED_HIGH, tlpq_pkg::SERVED_MEDIUM, tlpq_pkg::SERVED_LOW};

    logic [tlpq_pkg::ENTRY_W-1:0] job_slots [tlpq_pkg::NUM_QUEUES][QUEUE_DEPTH];
    int                 head_ptr  [tlpq_pkg::NUM_QUEUES];
    int                 tail_ptr  [tlpq_pkg::NUM_QUEUES];
    int                 fill      [tlpq_pkg::NUM_QUEUES];
    t_job_result        expected_results [$];
    int                 fail_total    = 0;
    int                 pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    function automatic t_job_result predict_job_result(
        input logic                        op,
        input logic [tlpq_pkg::JOB_W-1:0]  job_id,
        input logic [tlpq_pkg::JOB_W-1:0]  burst_length,
        input logic [2:0]                  level
    );
        t_job_result                  res;
        int                           q;
        logic [tlpq_pkg::ENTRY_W-1:0] entry;
        res = '0;
        if (op == tlpq_pkg::OP_ADD) begin
            case (level)
                tlpq_pkg::LEVEL_HIGH:   q = 0;
                tlpq_pkg::LEVEL_MEDIUM: q = 1;
                tlpq_pkg::LEVEL_LOW:    q = 2;
                default:                q = -1;
            endcase
            if (q < 0) begin
                res.status = tlpq_pkg::STS_BAD_LEVEL;
            end else if (fill[q] >= QUEUE_DEPTH) begin
                res.status = tlpq_pkg::STS_FULL;
            end else begin
                job_slots[q][tail_ptr[q]] = {job_id, burst_length};
                tail_ptr[q] = (tail_ptr[q] + 1) % QUEUE_DEPTH;
                fill[q]++;
                res.status = tlpq_pkg::STS_QUEUED;
            end
        end else begin
            res.status = tlpq_pkg::STS_EMPTY;
            for (int k = 0; k < tlpq_pkg::NUM_QUEUES; k++) begin
                if (res.status == tlpq_pkg::STS_EMPTY && fill[k] != 0) begin
                    entry = job_slots[k][head_ptr[k]];
                    head_ptr[k] = (head_ptr[k] + 1) % QUEUE_DEPTH;
                    fill[k]--;
                    res.status       = tlpq_pkg::STS_DISPATCHED;
                    res.job_id       = entry[tlpq_pkg::ENTRY_W-1:tlpq_pkg::JOB_W];
                    res.burst_length = entry[tlpq_pkg::JOB_W-1:0];
                    res.level        = SERVED_CODE[k];
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_job_result exp_r;
        if (!i_rst_n) begin
            for (int k = 0; k < tlpq_pkg::NUM_QUEUES; k++) begin
                head_ptr[k] = 0;
                tail_ptr[k] = 0;
                fill[k]     = 0;
            end
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: status %0d", i_status);
                    fail_total++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_status !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d", exp_r.status, i_status);
                        fail_total++;
                    end
                    if (i_out_job_id !== exp_r.job_id) begin
                        $error("out_job_id: expected 0x%04h, actual 0x%04h",
                               exp_r.job_id, i_out_job_id);
                        fail_total++;
                    end
                    if (i_out_burst_length !== exp_r.burst_length) begin
                        $error("out_burst_length: expected 0x%04h, actual 0x%04h",
                               exp_r.burst_length, i_out_burst_length);
                        fail_total++;
                    end
                    if (i_out_level !== exp_r.level) begin
                        $error("out_level: expected %0d, actual %0d", exp_r.level, i_out_level);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(
                    predict_job_result(i_op, i_job_id, i_burst_length, i_level));
            end
        end
        pending_total = expected_results.size();
    end

endmodule

/* dv/three_level_priority_queue_scheduler_tb.sv */
module three_level_priority_queue_scheduler_tb;

    localparam int ITEMS_PER_PHASE = 667;
    localparam int PERIOD          = 20;

    logic                        clk;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic                        in_stall;
    logic                        in_op      = tlpq_pkg::OP_ADD;
    logic [tlpq_pkg::JOB_W-1:0]  in_job_id  = '0;
    logic [tlpq_pkg::JOB_W-1:0]  in_burst   = '0;
    logic [2:0]                  in_level   = '0;
    logic                        out_valid;
    logic                        out_stall  = 1'b0;
    logic [2:0]                  out_status;
    logic [tlpq_pkg::JOB_W-1:0]  out_job_id;
    logic [tlpq_pkg::JOB_W-1:0]  out_burst;
    logic [1:0]                  out_level;
    int                          fail_count;
    int                          pending;
    int                          tx_idle_pct = 28;
    int                          rx_idle_pct = 73;

    three_level_priority_queue_scheduler u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_valid            (in_valid),
        .o_stall            (in_stall),
        .i_op               (in_op),
        .i_job_id           (in_job_id),
        .i_burst_length     (in_burst),
        .i_level            (in_level),
        .o_valid            (out_valid),
        .i_stall            (out_stall),
        .o_status           (out_status),
        .o_out_job_id       (out_job_id),
        .o_out_burst_length (out_burst),
        .o_out_level        (out_level)
    );

    job_dispatch_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_op               (in_op),
        .i_job_id           (in_job_id),
        .i_burst_length     (in_burst),
        .i_level            (in_level),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_status           (out_status),
        .i_out_job_id       (out_job_id),
        .i_out_burst_length (out_burst),
        .i_out_level        (out_level),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        clk = 1'b0;
        forever #(PERIOD / 2) clk = ~clk;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    task automatic send_job_txn(
        input logic                        op,
        input logic [tlpq_pkg::JOB_W-1:0]  job_id,
        input logic [tlpq_pkg::JOB_W-1:0]  burst,
        input logic [2:0]                  level
    );
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_op     <= op;
        in_job_id <= job_id;
        in_burst  <= burst;
        in_level  <= level;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(negedge clk);
    endtask

    initial begin
        int         sent;
        int         add_pct;
        int         run_len;
        logic       op;
        logic [2:0] lvl;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 28; rx_idle_pct = 73; end
                1: begin tx_idle_pct = 73; rx_idle_pct = 28; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase

            if (ph == 0) begin
                send_job_txn(tlpq_pkg::OP_DISPATCH, 16'hFFFF, 16'hFFFF, 3'd7);
                send_job_txn(tlpq_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 3'd0);
                send_job_txn(tlpq_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 3'd7);
                send_job_txn(tlpq_pkg::OP_ADD, 16'h0000, 16'hFFFF, tlpq_pkg::LEVEL_MEDIUM);
                send_job_txn(tlpq_pkg::OP_ADD, 16'hFFFF, 16'h0000, tlpq_pkg::LEVEL_LOW);
                send_job_txn(tlpq_pkg::OP_ADD, 16'hFFFF, 16'h0000, tlpq_pkg::LEVEL_HIGH);
                send_job_txn(tlpq_pkg::OP_ADD, 16'h0000, 16'hFFFF, tlpq_pkg::LEVEL_HIGH);
                for (int k = 2; k < tlpq_pkg::QUEUE_DEPTH_DEF; k++) begin
                    send_job_txn(tlpq_pkg::OP_ADD, 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 65535)), tlpq_pkg::LEVEL_HIGH);
                end
                send_job_txn(tlpq_pkg::OP_ADD, 16'h1234, 16'h5678, tlpq_pkg::LEVEL_HIGH);
                repeat (3) send_job_txn(tlpq_pkg::OP_DISPATCH, 16'h0000, 16'h0000, 3'd0);
                hold_until_drained();
            end

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                add_pct = $urandom_range(0, 1) ? 80 : 25;
                run_len = $urandom_range(5, 40);
                repeat (run_len) begin
                    op  = ($urandom_range(0, 99) < add_pct) ? tlpq_pkg::OP_ADD
                                                             : tlpq_pkg::OP_DISPATCH;
                    lvl = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(1, 3))
                                                       : 3'($urandom_range(0, 7));
                    send_job_txn(op, 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 65535)), lvl);
                    sent++;
                end
            end
            hold_until_drained();
        end

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("three_level_priority_queue_scheduler verification clean");
        end else begin
            $display("three_level_priority_queue_scheduler verification failed");
        end
        $finish;
    end

    initial begin
        #(PERIOD * 1000000);
        $display("three_level_priority_queue_scheduler verification failed");
        $finish;
    end

endmodule

/* files.f */
hdl/tlpq_pkg.sv
hdl/tlpq_ctrl.sv
hdl/tlpq_datapath.sv
hdl/three_level_priority_queue_scheduler.sv
dv/job_dispatch_checker.sv
dv/three_level_priority_queue_scheduler_tb.sv
